[hw/rtl/gtw_pkg.sv]
// Shared types and constants of the greedy text word wrapper.
package gtw_pkg;

	localparam int WORD_MAX_DEF = 32;
	localparam int SUM_W        = 10;
	localparam int CFG_ADDR_W   = 1;
	localparam int CFG_DATA_W   = 8;
	localparam int USER_W       = 3;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_SP  = 8'h20;

	localparam logic [4:0] INDENT_CAP   = 5'd29;
	localparam logic [7:0] COL_RESET    = 8'd80;
	localparam logic [4:0] INDENT_RESET = 5'd0;
	localparam logic [7:0] LINE_MAX     = 8'hFF;

	localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_LIMIT = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_INDENT       = 1'b1;

	typedef struct packed {
		logic       trunc;
		logic       text_end;
		logic       last;
		logic       byte_valid;
		logic [7:0] data;
	} item_t;

endpackage

[hw/rtl/greedy_text_word_wrapper.sv]
// Greedy text word wrapper: top level with word RAM, flush sequencer and output queue.
//
// Text bytes enter one per transaction; byte 0 ends the text. A word byte is written into
// the word RAM while the word holds fewer than WORD_MAX bytes; later bytes are dropped and
// mark the word truncated. A whitespace or end byte that closes a pending word starts a
// flush: the sequencer produces one result per cycle while the output queue accepts
// (newline, paragraph newline, indent spaces, separator, then the word bytes read from the
// RAM, and for an end byte the end item). The next byte is taken only once the sequencer
// is idle and its last result has passed into the output queue. An end byte with no
// pending word yields its end item the same way. A stalled result side holds the
// sequencer. The word RAM needs no clearing after reset; only written entries
// are ever read.
module greedy_text_word_wrapper #(
	parameter int WORD_MAX = gtw_pkg::WORD_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // text_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // out_byte
	output logic                            m_axis_tlast,  // run_last
	output logic [gtw_pkg::USER_W-1:0]      m_axis_tuser,  // byte_valid, text_end, word_truncated
	input  logic                            cfg_we,
	input  logic [gtw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [gtw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int LEN_W  = $clog2(WORD_MAX + 1);
	localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
	localparam int CNT_W  = (LEN_W > 5) ? LEN_W : 5;
	localparam int SUM_W  = gtw_pkg::SUM_W;

	typedef enum logic [2:0] {
		S_IDLE, S_NL, S_PARA, S_PAD, S_SEP, S_WORD, S_END
	} state_t;

	state_t state_q, nxt_state, start_state;

	logic [7:0]       col_q;
	logic [4:0]       indent_q;
	logic [7:0]       lp_q;
	logic [LEN_W-1:0] wl_q;
	logic             hw_q;
	logic             pp_q;
	logic [1:0]       nr_q;
	logic             ovf_q;

	logic [CNT_W-1:0] cnt_q, nxt_cnt;
	logic [LEN_W-1:0] flen_q;
	logic             para_q;
	logic             end_q;
	logic             trunc_q;

	logic              s1_valid_q;
	gtw_pkg::item_t    s1_item_q;
	logic              s1_ram_q;
	logic [ADDR_W-1:0] s1_addr_q;

	logic [4:0]       eff_ind, new_eff_ind;
	logic             in_acc, is_end, is_blank, has_word, flush_start;
	logic             on_line, wrap, sep;
	logic [SUM_W-1:0] fit_sum, new_sum;
	logic [7:0]       base_lp, lp_new;
	logic             fire, emit_ready, ram_we;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]       ram_rdata;
	gtw_pkg::item_t   gen_item, emit_item;

	assign eff_ind     = (indent_q > gtw_pkg::INDENT_CAP) ? gtw_pkg::INDENT_CAP : indent_q;
	assign new_eff_ind = (cfg_wdata[4:0] > gtw_pkg::INDENT_CAP) ? gtw_pkg::INDENT_CAP
	                                                            : cfg_wdata[4:0];

	assign s_axis_tready = (state_q == S_IDLE) && !s1_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_end        = (s_axis_tdata == gtw_pkg::CHAR_NUL);
	assign has_word      = (wl_q != '0);
	assign flush_start   = in_acc && (is_end || is_blank) && has_word;

	always_comb begin
		is_blank = s_axis_tdata inside {[8'd9:8'd13], gtw_pkg::CHAR_SP};
	end

	assign on_line = (lp_q != {3'b000, eff_ind});
	assign fit_sum = SUM_W'(lp_q) + SUM_W'(wl_q) + SUM_W'(1);
	assign wrap    = (fit_sum > SUM_W'(col_q)) && on_line;
	assign sep     = on_line && !wrap;
	assign base_lp = wrap ? {3'b000, eff_ind} : lp_q;
	assign new_sum = SUM_W'(base_lp) + SUM_W'(wl_q) + SUM_W'(sep);
	assign lp_new  = (new_sum > SUM_W'(gtw_pkg::LINE_MAX)) ? gtw_pkg::LINE_MAX : new_sum[7:0];

	assign ram_we = in_acc && !is_end && !is_blank && (wl_q < LEN_W'(WORD_MAX));

	always_comb begin
		if (wrap) begin
			start_state = S_NL;
		end else if (sep) begin
			start_state = S_SEP;
		end else begin
			start_state = S_WORD;
		end
	end

	always_comb begin
		nxt_state = S_IDLE;
		nxt_cnt   = '0;
		case (state_q)
			S_NL: begin
				if (para_q) begin
					nxt_state = S_PARA;
				end else begin
					nxt_state = (eff_ind != 5'd0) ? S_PAD : S_WORD;
				end
			end
			S_PARA: begin
				nxt_state = (eff_ind != 5'd0) ? S_PAD : S_WORD;
			end
			S_PAD: begin
				if (cnt_q + CNT_W'(1) == CNT_W'(eff_ind)) begin
					nxt_state = S_WORD;
				end else begin
					nxt_state = S_PAD;
					nxt_cnt   = cnt_q + CNT_W'(1);
				end
			end
			S_SEP: begin
				nxt_state = S_WORD;
			end
			S_WORD: begin
				if (cnt_q + CNT_W'(1) == CNT_W'(flen_q)) begin
					nxt_state = end_q ? S_END : S_IDLE;
				end else begin
					nxt_state = S_WORD;
					nxt_cnt   = cnt_q + CNT_W'(1);
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_comb begin
		gen_item.data       = gtw_pkg::CHAR_SP;
		gen_item.byte_valid = 1'b1;
		gen_item.last       = (nxt_state == S_IDLE);
		gen_item.text_end   = 1'b0;
		gen_item.trunc      = trunc_q;
		case (state_q)
			S_NL, S_PARA: begin
				gen_item.data = gtw_pkg::CHAR_NL;
			end
			S_END: begin
				gen_item.data       = gtw_pkg::CHAR_NUL;
				gen_item.byte_valid = 1'b0;
				gen_item.text_end   = 1'b1;
				gen_item.trunc      = 1'b0;
			end
			default: begin
				gen_item.data = gtw_pkg::CHAR_SP;
			end
		endcase
	end

	assign fire  = (state_q != S_IDLE) && (!s1_valid_q || emit_ready);
	assign raddr = fire ? cnt_q[ADDR_W-1:0] : s1_addr_q;

	always_comb begin
		emit_item = s1_item_q;
		if (s1_ram_q) begin
			emit_item.data = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			flen_q     <= '0;
			para_q     <= 1'b0;
			end_q      <= 1'b0;
			trunc_q    <= 1'b0;
			s1_valid_q <= 1'b0;
			s1_item_q  <= '0;
			s1_ram_q   <= 1'b0;
			s1_addr_q  <= '0;
			col_q      <= gtw_pkg::COL_RESET;
			indent_q   <= gtw_pkg::INDENT_RESET;
			lp_q       <= {3'b000, gtw_pkg::INDENT_RESET};
			wl_q       <= '0;
			hw_q       <= 1'b0;
			pp_q       <= 1'b0;
			nr_q       <= 2'd0;
			ovf_q      <= 1'b0;
		end else begin
			if (fire) begin
				state_q    <= nxt_state;
				cnt_q      <= nxt_cnt;
				s1_valid_q <= 1'b1;
				s1_item_q  <= gen_item;
				s1_ram_q   <= (state_q == S_WORD);
				s1_addr_q  <= cnt_q[ADDR_W-1:0];
			end else if (emit_ready) begin
				s1_valid_q <= 1'b0;
			end

			if (in_acc) begin
				if (flush_start) begin
					state_q <= start_state;
					cnt_q   <= '0;
					flen_q  <= wl_q;
					para_q  <= pp_q;
					end_q   <= is_end;
					trunc_q <= ovf_q;
				end else if (is_end) begin
					state_q <= S_END;
					trunc_q <= 1'b0;
				end

				if (is_end) begin
					wl_q  <= '0;
					lp_q  <= {3'b000, eff_ind};
					hw_q  <= 1'b0;
					pp_q  <= 1'b0;
					nr_q  <= 2'd0;
					ovf_q <= 1'b0;
				end else if (is_blank) begin
					if (has_word) begin
						lp_q  <= lp_new;
						wl_q  <= '0;
						ovf_q <= 1'b0;
						if (wrap) begin
							hw_q <= 1'b1;
							pp_q <= 1'b0;
						end
					end
					if (s_axis_tdata == gtw_pkg::CHAR_NL && nr_q != 2'd3) begin
						nr_q <= nr_q + 2'd1;
					end
				end else begin
					if (!has_word) begin
						if (hw_q && nr_q >= 2'd2) begin
							pp_q <= 1'b1;
						end
						nr_q <= 2'd0;
					end
					if (ram_we) begin
						wl_q <= wl_q + LEN_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_addr)
					gtw_pkg::REG_COLUMN_LIMIT: begin
						col_q <= cfg_wdata;
					end
					gtw_pkg::REG_INDENT: begin
						indent_q <= cfg_wdata[4:0];
						if (lp_q == {3'b000, eff_ind}) begin
							lp_q <= {3'b000, new_eff_ind};
						end
					end
					default: begin
						col_q <= col_q;
					end
				endcase
			end
		end
	end

	gtw_ram #(
		.WIDTH (8),
		.DEPTH (WORD_MAX),
		.ADDR_W(ADDR_W)
	) u_word_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wl_q[ADDR_W-1:0]),
		.wdata(s_axis_tdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	gtw_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (s1_valid_q && emit_ready),
		.item         (emit_item),
		.in_ready     (emit_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("end-of-text transaction not marked last or carries a byte");

	a_no_write_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE) && !s1_valid_q)
		else $error("word RAM written while a flush is reading it");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wl_q <= LEN_W'(WORD_MAX))
		else $error("word length beyond buffer depth");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		flush_start |=> state_q != S_IDLE)
		else $error("flush started without a sequence");

endmodule

[hw/rtl/gtw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module gtw_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/gtw_emit.sv]
// Two-entry output queue that drives the result stream.
module gtw_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  gtw_pkg::item_t              item,
	output logic                        in_ready,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // out_byte
	output logic                        m_axis_tlast,  // run_last
	output logic [gtw_pkg::USER_W-1:0]  m_axis_tuser   // byte_valid, text_end, word_truncated
);

	gtw_pkg::item_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       pop;
	gtw_pkg::item_t head;

	assign in_ready      = (cnt_q != 2'd2);
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign head          = ent_q[rp_q];
	assign m_axis_tdata  = head.data;
	assign m_axis_tlast  = head.last;
	assign m_axis_tuser  = {head.trunc, head.text_end, head.byte_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= item;
		end
	end

endmodule
